FILE: rtl/wbsm_pkg.sv
// Shared types and field widths for the wildcard byte signature matcher.
`timescale 1ns / 1ps
`default_nettype none

package wbsm_pkg;

  localparam int FUNC_W   = 2;
  localparam int SIG_W    = 4;
  localparam int POS_W    = 5;
  localparam int BYTE_W   = 8;
  localparam int PLEN_W   = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PAT_WRITE = 2'd0,
    FUNC_SET_LEN   = 2'd1,
    FUNC_DATA      = 2'd2,
    FUNC_END       = 2'd3
  } func_t;

  typedef struct packed {
    func_t               func;
    logic [SIG_W-1:0]    sig_index;
    logic [POS_W-1:0]    position;
    logic [BYTE_W-1:0]   pattern_byte;
    logic                is_wildcard;
    logic [PLEN_W-1:0]   pattern_length;
    logic [BYTE_W-1:0]   data_byte;
  } item_t;

  // One command into the match engine: go marks the cycle the item is applied.
  typedef struct packed {
    logic  go;
    item_t item;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/wbsm_match_engine.sv
// Pattern cells, lengths, shift-and vectors and sticky found flags for all slots.
`timescale 1ns / 1ps
`default_nettype none

module wbsm_match_engine #(
  parameter int NUM_SIGS = 16,
  parameter int MAX_LEN  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire wbsm_pkg::cmd_t        cmd,
  output logic [NUM_SIGS-1:0]        found
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  logic [LEN_W-1:0] len_sat;

  // Lengths above the pattern depth saturate
  always_comb begin
    if (32'(cmd.item.pattern_length) > MAX_LEN) begin
      len_sat = LEN_W'(MAX_LEN);
    end else begin
      len_sat = LEN_W'(cmd.item.pattern_length);
    end
  end

  for (genvar s = 0; s < NUM_SIGS; s++) begin : g_slot
    logic [7:0]         pat_q [MAX_LEN];
    logic [MAX_LEN-1:0] wild_q;
    logic [LEN_W-1:0]   len_q;
    logic [MAX_LEN-1:0] vec_q;
    logic               flag_q;
    logic [MAX_LEN-1:0] mask;
    logic [MAX_LEN-1:0] vec_next;
    logic               hit;
    logic               sel;
    logic               pat_we;

    assign sel    = (32'(cmd.item.sig_index) == s);
    assign pat_we = cmd.go && (cmd.item.func == wbsm_pkg::FUNC_PAT_WRITE) && sel;

    // Each cell compares its own pattern byte with the broadcast data byte
    always_comb begin
      hit = 1'b0;
      for (int j = 0; j < MAX_LEN; j++) begin
        mask[j] = (wild_q[j] || (pat_q[j] == cmd.item.data_byte)) && (32'(len_q) > j);
      end
      vec_next = ((vec_q << 1) | MAX_LEN'(1)) & mask;
      for (int j = 0; j < MAX_LEN; j++) begin
        if (vec_next[j] && (32'(len_q) == j + 1)) begin
          hit = 1'b1;
        end
      end
    end

    // Pattern cells: undefined until written
    always_ff @(posedge clk) begin
      for (int j = 0; j < MAX_LEN; j++) begin
        if (pat_we && (32'(cmd.item.position) == j)) begin
          pat_q[j]  <= cmd.item.pattern_byte;
          wild_q[j] <= cmd.item.is_wildcard;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        len_q  <= '0;
        vec_q  <= '0;
        flag_q <= 1'b0;
      end else if (cmd.go) begin
        unique case (cmd.item.func)
          wbsm_pkg::FUNC_PAT_WRITE: begin
          end
          wbsm_pkg::FUNC_SET_LEN: begin
            if (sel) begin
              len_q <= len_sat;
              vec_q <= '0;
            end
          end
          wbsm_pkg::FUNC_DATA: begin
            vec_q <= vec_next;
            if (hit) begin
              flag_q <= 1'b1;
            end
          end
          wbsm_pkg::FUNC_END: begin
            vec_q  <= '0;
            flag_q <= 1'b0;
          end
        endcase
      end
    end

    assign found[s] = flag_q;
  end

endmodule

`default_nettype wire

FILE: rtl/wbsm_reporter.sv
// Holds a snapshot of the found flags and plays it out one report beat per slot.
`timescale 1ns / 1ps
`default_nettype none

module wbsm_reporter #(
  parameter int NUM_SIGS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire logic [NUM_SIGS-1:0]          flags,
  output logic                              can_load,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [wbsm_pkg::SIG_W-1:0]        result_sig,
  output logic                              matched,
  output logic                              last
);

  localparam int IDX_W = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;

  logic                busy;
  logic [NUM_SIGS-1:0] snap;
  logic [IDX_W-1:0]    idx;
  logic                last_q;
  logic                beat;

  assign beat     = busy && out_ready;
  assign can_load = !busy || (beat && last_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (beat && last_q) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap   <= flags;
      idx    <= '0;
      last_q <= (NUM_SIGS == 1);
    end else if (beat && !last_q) begin
      snap   <= snap >> 1;
      idx    <= idx + IDX_W'(1);
      last_q <= (32'(idx) + 2 == NUM_SIGS);
    end
  end

  assign out_valid  = busy;
  assign matched    = snap[0];
  assign result_sig = wbsm_pkg::SIG_W'(32'(idx));
  assign last       = last_q;

endmodule

`default_nettype wire

FILE: rtl/wildcard_byte_signature_matcher_core.sv
// Top level: input register, match engine and report sequencer.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------------
//  in      | sink      | in_valid / in_ready | func sig_index position pattern_byte
//          |           |                     | is_wildcard pattern_length data_byte
//  out     | source    | out_valid/out_ready | result_sig matched last
//
// Items are registered, then sent to all slots: data and end items act on all of them,
// write and length items only on slot sig_index. End of buffer yields NUM_SIGS report
// beats, one per cycle while out_ready is high. Data, write and length items keep flowing
// while reports drain; one item per cycle is taken, but a second end of buffer waits in
// the input register until the last report beat of the previous one is taken.
// Reset clears lengths, vectors, flags and handshake state; pattern cells are not reset.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_signature_matcher_core #(
  parameter int NUM_SIGS = 16,
  parameter int MAX_LEN  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [wbsm_pkg::FUNC_W-1:0]   func,
  input  wire logic [wbsm_pkg::SIG_W-1:0]    sig_index,
  input  wire logic [wbsm_pkg::POS_W-1:0]    position,
  input  wire logic [wbsm_pkg::BYTE_W-1:0]   pattern_byte,
  input  wire logic                          is_wildcard,
  input  wire logic [wbsm_pkg::PLEN_W-1:0]   pattern_length,
  input  wire logic [wbsm_pkg::BYTE_W-1:0]   data_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [wbsm_pkg::SIG_W-1:0]         result_sig,
  output logic                               matched,
  output logic                               last
);

  logic                  s1_valid;
  wbsm_pkg::item_t       s1_item;
  logic                  s1_go;
  logic                  s1_is_end;
  logic                  rep_load;
  logic                  can_load;
  wbsm_pkg::cmd_t        cmd;
  logic [NUM_SIGS-1:0]   found;

  assign s1_is_end = (s1_item.func == wbsm_pkg::FUNC_END);
  assign s1_go     = s1_valid && (!s1_is_end || can_load);
  assign rep_load  = s1_valid && s1_is_end && can_load;
  assign in_ready  = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.func           <= wbsm_pkg::func_t'(func);
      s1_item.sig_index      <= sig_index;
      s1_item.position       <= position;
      s1_item.pattern_byte   <= pattern_byte;
      s1_item.is_wildcard    <= is_wildcard;
      s1_item.pattern_length <= pattern_length;
      s1_item.data_byte      <= data_byte;
    end
  end

  assign cmd.go   = s1_go;
  assign cmd.item = s1_item;

  wbsm_match_engine #(
    .NUM_SIGS (NUM_SIGS),
    .MAX_LEN  (MAX_LEN)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .found (found)
  );

  wbsm_reporter #(
    .NUM_SIGS (NUM_SIGS)
  ) u_reporter (
    .clk        (clk),
    .rst        (rst),
    .load       (rep_load),
    .flags      (found),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_sig (result_sig),
    .matched    (matched),
    .last       (last)
  );

  // Only an end of buffer behind a draining report may hold the input register
  a_stall_only_on_end: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |-> s1_is_end && out_valid)
    else $error("input register stalled on a non end beat");

  a_load_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    rep_load |=> out_valid && (result_sig == '0))
    else $error("report sequence did not start at slot zero");

  a_slot_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && (result_sig == $past(result_sig) + 4'd1))
    else $error("report slot did not advance by one");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last && !rep_load |=> !out_valid)
    else $error("reports continued past the last slot");

endmodule

`default_nettype wire
